// ----- hw/rtl/lbdc_pkg.sv -----
// Shared types, codes and the beam transition table of the light-barrier
// direction counter. No dependencies.
package lbdc_pkg;

  // Default parameter values
  localparam int STAMP_BITS_DEF = 48;
  localparam int TOTAL_BITS_DEF = 16;

  // Fixed field widths
  localparam int CFG_W  = 32;
  localparam int OCC_W  = 16;
  localparam int BEAM_W = 2;
  localparam int PASS_W = 2;
  localparam int HIST_W = 3 * BEAM_W;

  localparam logic [CFG_W-1:0] EXPIRE_RESET = 32'd100000;

  // Status codes
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;

  // Passage codes
  localparam logic [PASS_W-1:0] PASS_NONE  = 2'd0;
  localparam logic [PASS_W-1:0] PASS_ENTRY = 2'd1;
  localparam logic [PASS_W-1:0] PASS_EXIT  = 2'd2;

  // Beam states: bit0 first beam blocked, bit1 second beam blocked
  localparam logic [BEAM_W-1:0] BEAM_IDLE   = 2'd0;
  localparam logic [BEAM_W-1:0] BEAM_FIRST  = 2'd1;
  localparam logic [BEAM_W-1:0] BEAM_SECOND = 2'd2;
  localparam logic [BEAM_W-1:0] BEAM_BOTH   = 2'd3;

  // History patterns, oldest state in the top bits
  localparam logic [HIST_W-1:0] HIST_ENTRY_A = {BEAM_FIRST,  BEAM_IDLE, BEAM_SECOND};
  localparam logic [HIST_W-1:0] HIST_ENTRY_B = {BEAM_FIRST,  BEAM_BOTH, BEAM_SECOND};
  localparam logic [HIST_W-1:0] HIST_EXIT_A  = {BEAM_SECOND, BEAM_IDLE, BEAM_FIRST};
  localparam logic [HIST_W-1:0] HIST_EXIT_B  = {BEAM_SECOND, BEAM_BOTH, BEAM_FIRST};

  typedef struct packed {
    logic              ok;
    logic [BEAM_W-1:0] state;
  } lbdc_move_t;

  // Result of one event
  typedef struct packed {
    logic                    status;
    logic [PASS_W-1:0]       passage;
    logic signed [OCC_W-1:0] occupancy;
    logic [BEAM_W-1:0]       beam_state;
  } lbdc_res_t;

  // Next beam state from current state and {sensor, level}
  function automatic lbdc_move_t next_beam(input logic [BEAM_W-1:0] cur,
                                           input logic [1:0] evt_code);
    lbdc_move_t mv;
    mv.ok    = 1'b1;
    mv.state = BEAM_IDLE;
    case ({cur, evt_code})
      {BEAM_IDLE,   2'd1}: mv.state = BEAM_FIRST;
      {BEAM_IDLE,   2'd3}: mv.state = BEAM_SECOND;
      {BEAM_FIRST,  2'd0}: mv.state = BEAM_IDLE;
      {BEAM_FIRST,  2'd3}: mv.state = BEAM_BOTH;
      {BEAM_SECOND, 2'd1}: mv.state = BEAM_BOTH;
      {BEAM_SECOND, 2'd2}: mv.state = BEAM_IDLE;
      {BEAM_BOTH,   2'd0}: mv.state = BEAM_SECOND;
      {BEAM_BOTH,   2'd2}: mv.state = BEAM_FIRST;
      default:             mv.ok    = 1'b0;
    endcase
    return mv;
  endfunction

endpackage

// ----- hw/rtl/lbdc_if.sv -----
// Channel interfaces of the light-barrier direction counter: sensor events,
// results and configuration writes. Depends on lbdc_pkg.
interface lbdc_evt_if #(parameter int STAMP_BITS = lbdc_pkg::STAMP_BITS_DEF);
  logic                  valid;
  logic                  ready;
  logic [STAMP_BITS-1:0] stamp;
  logic                  sensor_id;
  logic                  new_level;
  modport source (output valid, stamp, sensor_id, new_level, input ready);
  modport sink   (input valid, stamp, sensor_id, new_level, output ready);
endinterface

interface lbdc_res_if;
  logic                              valid;
  logic                              ready;
  logic                              status;
  logic [lbdc_pkg::PASS_W-1:0]       passage;
  logic signed [lbdc_pkg::OCC_W-1:0] occupancy;
  logic [lbdc_pkg::BEAM_W-1:0]       beam_state;
  modport source (output valid, status, passage, occupancy, beam_state, input ready);
  modport sink   (input valid, status, passage, occupancy, beam_state, output ready);
endinterface

interface lbdc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lbdc_pkg::CFG_W-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/lbdc_pipe_reg.sv -----
// One valid/ready register stage, full rate unless the output stalls,
// used on both sides of the tracker. No dependencies.
module lbdc_pipe_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_vld,
  output logic         in_rdy,
  input  logic [W-1:0] in_data,
  output logic         out_vld,
  input  logic         out_rdy,
  output logic [W-1:0] out_data
);

  // Take a new transaction when empty or when the held one leaves
  assign in_rdy = !out_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (in_rdy) begin
      out_vld <= in_vld;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      out_data <= in_data;
    end
  end

endmodule

// ----- hw/rtl/lbdc_core.sv -----
// Beam tracker: state machine, history, expiry and saturating count.
// Advances once per step. Depends on lbdc_pkg.
module lbdc_core #(
  parameter int STAMP_BITS = lbdc_pkg::STAMP_BITS_DEF,
  parameter int TOTAL_BITS = lbdc_pkg::TOTAL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [STAMP_BITS-1:0]       stamp,
  input  logic                        sensor_id,
  input  logic                        new_level,
  input  logic [lbdc_pkg::CFG_W-1:0]  expire_ticks,
  output lbdc_pkg::lbdc_res_t         res
);

  localparam int CMP_W = (STAMP_BITS > lbdc_pkg::CFG_W) ? STAMP_BITS : lbdc_pkg::CFG_W;
  localparam logic signed [TOTAL_BITS-1:0] TOTAL_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
  localparam logic signed [TOTAL_BITS-1:0] TOTAL_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

  logic [lbdc_pkg::BEAM_W-1:0] beam, beam_next;
  logic [lbdc_pkg::HIST_W-1:0] hist, hist_next;
  logic [STAMP_BITS-1:0]       last_stamp;
  logic signed [TOTAL_BITS-1:0] total, total_next;

  logic [STAMP_BITS-1:0]        gap;
  logic                         expired;
  logic [lbdc_pkg::HIST_W-1:0]  hist_base;
  lbdc_pkg::lbdc_move_t         mv;
  logic [lbdc_pkg::PASS_W-1:0]  passage;

  // Check the idle gap, modulo the stamp width
  assign gap     = stamp - last_stamp;
  assign expired = (beam == lbdc_pkg::BEAM_IDLE) &&
                   (CMP_W'(gap) > CMP_W'(expire_ticks));
  assign hist_base = expired ? '0 : hist;

  assign mv = lbdc_pkg::next_beam(beam, {sensor_id, new_level});

  // Move the beam state, shift history, detect passages and count
  always_comb begin
    beam_next  = lbdc_pkg::BEAM_IDLE;
    hist_next  = hist_base;
    total_next = total;
    passage    = lbdc_pkg::PASS_NONE;
    if (mv.ok) begin
      beam_next = mv.state;
      hist_next = {hist_base[lbdc_pkg::HIST_W-lbdc_pkg::BEAM_W-1:0], mv.state};
      if (hist_next == lbdc_pkg::HIST_ENTRY_A || hist_next == lbdc_pkg::HIST_ENTRY_B) begin
        passage = lbdc_pkg::PASS_ENTRY;
        if (total != TOTAL_MAX) begin
          total_next = total + TOTAL_BITS'(1);
        end
      end else if (hist_next == lbdc_pkg::HIST_EXIT_A ||
                   hist_next == lbdc_pkg::HIST_EXIT_B) begin
        passage = lbdc_pkg::PASS_EXIT;
        if (total != TOTAL_MIN) begin
          total_next = total - TOTAL_BITS'(1);
        end
      end
    end
  end

  // Result of this step
  always_comb begin
    res.status     = mv.ok ? lbdc_pkg::ST_OK : lbdc_pkg::ST_BAD;
    res.passage    = passage;
    res.occupancy  = lbdc_pkg::OCC_W'(total_next);
    res.beam_state = beam_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam       <= lbdc_pkg::BEAM_IDLE;
      hist       <= '0;
      last_stamp <= '0;
      total      <= '0;
    end else if (step) begin
      beam       <= beam_next;
      hist       <= hist_next;
      last_stamp <= stamp;
      total      <= total_next;
    end
  end

endmodule

// ----- hw/rtl/light_barrier_direction_counter_top.sv -----
// Top level of the light-barrier direction counter: input stage, tracker,
// result stage and expiry register. Depends on lbdc_pkg, lbdc_if, lbdc_pipe_reg,
// lbdc_core.
//
//   channel  dir  payload                                      transaction
//   evt      in   stamp, sensor_id, new_level                  valid & ready
//   res      out  status, passage, occupancy, beam_state       valid & ready
//   cfg      in   data (expire_ticks)                          valid & ready
//
// One event per cycle while res is not stalled. An accepted event goes into the
// input register, then through the tracker logic into the result register.
// rst is synchronous: clears state, count, history and sets expiry to 100000.
// A stalled res holds its result; the input stage keeps taking events while
// the result register drains, and stalls only when both stages are full.
// cfg is always ready.
module light_barrier_direction_counter_top #(
  parameter int STAMP_BITS = lbdc_pkg::STAMP_BITS_DEF,
  parameter int TOTAL_BITS = lbdc_pkg::TOTAL_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  lbdc_evt_if.sink evt,
  lbdc_res_if.source res,
  lbdc_cfg_if.sink cfg
);

  localparam int EVT_W = STAMP_BITS + 2;
  localparam int RES_W = $bits(lbdc_pkg::lbdc_res_t);

  logic [lbdc_pkg::CFG_W-1:0] expire_ticks;

  logic             s1_vld;
  logic [EVT_W-1:0] s1_data;
  logic             s2_rdy;
  logic             step;
  lbdc_pkg::lbdc_res_t step_res;
  lbdc_pkg::lbdc_res_t out_res;

  // Hold the expiry limit
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expire_ticks <= lbdc_pkg::EXPIRE_RESET;
    end else if (cfg.valid) begin
      expire_ticks <= cfg.data;
    end
  end

  // Register incoming events
  lbdc_pipe_reg #(.W(EVT_W)) u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (evt.valid),
    .in_rdy   (evt.ready),
    .in_data  ({evt.stamp, evt.sensor_id, evt.new_level}),
    .out_vld  (s1_vld),
    .out_rdy  (s2_rdy),
    .out_data (s1_data)
  );

  // Advance the tracker when the event moves into the result stage
  assign step = s1_vld && s2_rdy;

  lbdc_core #(
    .STAMP_BITS (STAMP_BITS),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .stamp        (s1_data[EVT_W-1:2]),
    .sensor_id    (s1_data[1]),
    .new_level    (s1_data[0]),
    .expire_ticks (expire_ticks),
    .res          (step_res)
  );

  // Register results
  lbdc_pipe_reg #(.W(RES_W)) u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s1_vld),
    .in_rdy   (s2_rdy),
    .in_data  (step_res),
    .out_vld  (res.valid),
    .out_rdy  (res.ready),
    .out_data (out_res)
  );

  assign res.status     = out_res.status;
  assign res.passage    = out_res.passage;
  assign res.occupancy  = out_res.occupancy;
  assign res.beam_state = out_res.beam_state;

`ifndef ASSERT_OFF
  // A rejected edge reports idle beams and no passage
  a_bad_is_idle: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == lbdc_pkg::ST_BAD) |->
      (res.passage == lbdc_pkg::PASS_NONE && res.beam_state == lbdc_pkg::BEAM_IDLE))
    else $error("rejected edge with passage or blocked beam");

  // An entry ends with only the second beam blocked
  a_entry_state: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.passage == lbdc_pkg::PASS_ENTRY) |->
      (res.status == lbdc_pkg::ST_OK && res.beam_state == lbdc_pkg::BEAM_SECOND))
    else $error("entry counted in wrong beam state");

  // An exit ends with only the first beam blocked
  a_exit_state: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.passage == lbdc_pkg::PASS_EXIT) |->
      (res.status == lbdc_pkg::ST_OK && res.beam_state == lbdc_pkg::BEAM_FIRST))
    else $error("exit counted in wrong beam state");

  // An accepted event occupies the input stage next cycle
  a_evt_held: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && evt.ready) |=> s1_vld)
    else $error("accepted event lost");
`endif

endmodule
